>>> hdl/acs_pkg.sv
`timescale 1ns / 1ps

package acs_pkg;

  localparam int DEF_MAX_COLLIDERS   = 32;
  localparam int DEF_PIVOT_FRAC_BITS = 8;

  // the slot index is five bits wide, so no more than this many slots are ever scanned
  localparam int MAX_SCAN = 32;

  localparam int SLOT_W  = 5;
  localparam int POS_W   = 16;
  localparam int SIZE_W  = 13;
  localparam int SM1_W   = 12;
  localparam int PIV_W   = 9;
  localparam int CH_W    = 16;
  localparam int COORD_W = 18;

  typedef logic [SLOT_W-1:0]         slot_t;
  typedef logic signed [POS_W-1:0]   pos_t;
  typedef logic [SIZE_W-1:0]         size_t;
  typedef logic [SM1_W-1:0]          sm1_t;
  typedef logic [PIV_W-1:0]          piv_t;
  typedef logic [CH_W-1:0]           chan_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  localparam size_t SIZE_MAX     = size_t'(4096);
  localparam chan_t CHANNEL_NONE = '0;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_WRITE,
    S_SCAN,
    S_DONE
  } state_t;

  // query that travels down the row of cells
  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
    chan_t  chan;
    slot_t  self;
  } query_t;

  // slot write broadcast to every cell
  typedef struct packed {
    logic   upd;
    logic   clr;
    slot_t  idx;
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
    chan_t  resp;
    logic   active;
  } wr_t;

endpackage

>>> hdl/acs_edge.sv
`timescale 1ns / 1ps

module acs_edge #(
  parameter int PIVOT_FRAC_BITS = acs_pkg::DEF_PIVOT_FRAC_BITS
) (
  input  logic            clk,
  input  logic            ld,
  input  acs_pkg::pos_t   pos,
  input  acs_pkg::size_t  size,
  input  acs_pkg::piv_t   pivot,
  output acs_pkg::coord_t lo,
  output acs_pkg::coord_t hi
);

  localparam int PIV_ONE = 1 << PIVOT_FRAC_BITS;

  acs_pkg::size_t size_c;
  acs_pkg::sm1_t  sm1;
  acs_pkg::piv_t  piv_c;

  acs_pkg::pos_t  pos_r;
  acs_pkg::sm1_t  sm1_r;
  acs_pkg::piv_t  piv_r;
  acs_pkg::sm1_t  off_r;

  logic [acs_pkg::SM1_W+acs_pkg::PIV_W-1:0] prod;

  // saturate size and pivot to their legal ranges
  always_comb begin
    if (size == '0) begin
      size_c = acs_pkg::size_t'(1);
    end else if (size > acs_pkg::SIZE_MAX) begin
      size_c = acs_pkg::SIZE_MAX;
    end else begin
      size_c = size;
    end
    sm1 = acs_pkg::sm1_t'(size_c - acs_pkg::size_t'(1));
    if (int'(pivot) > PIV_ONE) begin
      piv_c = acs_pkg::piv_t'(PIV_ONE);
    end else begin
      piv_c = pivot;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      pos_r <= pos;
      sm1_r <= sm1;
      piv_r <= piv_c;
    end
  end

  assign prod = sm1_r * piv_r;

  // product is non-negative, so the shift is the truncated offset
  always_ff @(posedge clk) begin
    off_r <= acs_pkg::sm1_t'(prod >> PIVOT_FRAC_BITS);
  end

  assign lo = acs_pkg::coord_t'(pos_r) - acs_pkg::coord_t'(off_r);
  assign hi = lo + acs_pkg::coord_t'(sm1_r);

endmodule

>>> hdl/acs_cell.sv
`timescale 1ns / 1ps

module acs_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  acs_pkg::wr_t    wr,
  input  logic            adv,
  input  logic            tok_in_v,
  input  acs_pkg::query_t tok_in,
  output logic            tok_v_o,
  output acs_pkg::query_t tok_o,
  output logic            hit_o
);

  localparam acs_pkg::slot_t MY_IDX = acs_pkg::slot_t'(IDX);

  logic            valid_r;
  logic            active_r;
  acs_pkg::chan_t  resp_r;
  acs_pkg::coord_t l_r;
  acs_pkg::coord_t t_r;
  acs_pkg::coord_t r_r;
  acs_pkg::coord_t b_r;
  logic            tok_v_r;
  acs_pkg::query_t tok_r;

  logic sel;
  logic apart;
  logic match;

  assign sel = (wr.idx == MY_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      active_r <= 1'b0;
      tok_v_r  <= 1'b0;
    end else begin
      if (sel && wr.clr) begin
        valid_r  <= 1'b0;
        active_r <= 1'b0;
      end else if (sel && wr.upd) begin
        valid_r  <= 1'b1;
        active_r <= wr.active;
      end
      if (adv) begin
        tok_v_r <= tok_in_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && wr.upd) begin
      l_r    <= wr.l;
      t_r    <= wr.t;
      r_r    <= wr.r;
      b_r    <= wr.b;
      resp_r <= wr.resp;
    end
    if (adv) begin
      tok_r <= tok_in;
    end
  end

  // inclusive overlap test against the passing query box
  assign apart = (r_r < tok_r.l) || (l_r > tok_r.r) || (b_r < tok_r.t) || (t_r > tok_r.b);
  assign match = valid_r && active_r && ((tok_r.chan & resp_r) != acs_pkg::CHANNEL_NONE) &&
                 !apart && (tok_r.self != MY_IDX);

  assign hit_o   = tok_v_r && match;
  assign tok_v_o = tok_v_r;
  assign tok_o   = tok_r;

endmodule

>>> hdl/aabb_channel_collision_scan_core.sv
`timescale 1ns / 1ps
// Remove: gives no beat; the next item may follow at once.
// Update: box math in the operand and offset registers, then the query walks the row of slot
// cells, one a cycle while the output does not hold the row; no new item is taken until the
// final beat has been issued, and an update to a slot outside the row skips the walk.
// A hit beat is held until the next hit or the end of the scan, so the final one carries last.
// Reset (rst_n low, synchronous) empties every slot and drops any scan in flight.
module aabb_channel_collision_scan_core #(
  parameter int MAX_COLLIDERS   = acs_pkg::DEF_MAX_COLLIDERS,
  parameter int PIVOT_FRAC_BITS = acs_pkg::DEF_PIVOT_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [acs_pkg::SLOT_W-1:0]  in_slot,
  input  logic signed [15:0]          in_pos_x,
  input  logic signed [15:0]          in_pos_y,
  input  logic [acs_pkg::SIZE_W-1:0]  in_size_x,
  input  logic [acs_pkg::SIZE_W-1:0]  in_size_y,
  input  logic [acs_pkg::PIV_W-1:0]   in_pivot_x,
  input  logic [acs_pkg::PIV_W-1:0]   in_pivot_y,
  input  logic [acs_pkg::CH_W-1:0]    in_query_channel,
  input  logic [acs_pkg::CH_W-1:0]    in_response_mask,
  input  logic                        in_owner_active,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic [acs_pkg::SLOT_W-1:0]  out_hit_slot,
  output logic                        out_last
);

  localparam int NCELL = (MAX_COLLIDERS < acs_pkg::MAX_SCAN) ? MAX_COLLIDERS : acs_pkg::MAX_SCAN;

  acs_pkg::state_t state_r, state_nxt;

  logic in_acc, upd_acc, rem_acc, slot_ok;
  logic launch, emit_done, out_free, adv, cur_hit, tok_exit;

  acs_pkg::chan_t  q_chan_r;
  acs_pkg::chan_t  resp_r;
  logic            act_r;
  acs_pkg::slot_t  self_r;
  logic            ok_r;

  acs_pkg::coord_t box_l, box_r, box_t, box_b;
  acs_pkg::wr_t    wr;
  acs_pkg::query_t q0;
  acs_pkg::slot_t  hit_idx;

  logic [NCELL-1:0] tok_v;
  logic [NCELL-1:0] hit;
  acs_pkg::query_t  tok [NCELL];

  logic           pend_v_r, pend_v_nxt;
  acs_pkg::slot_t pend_slot_r, pend_slot_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_hit_r, out_hit_nxt;
  acs_pkg::slot_t out_slot_r, out_slot_nxt;
  logic           out_last_r, out_last_nxt;

  assign in_acc  = in_valid && in_ready;
  assign upd_acc = in_acc && (in_action == acs_pkg::ACT_UPDATE);
  assign rem_acc = in_acc && (in_action == acs_pkg::ACT_REMOVE);
  assign slot_ok = int'(in_slot) < NCELL;

  always_ff @(posedge clk) begin
    if (upd_acc) begin
      q_chan_r <= in_query_channel;
      resp_r   <= in_response_mask;
      act_r    <= in_owner_active;
      self_r   <= in_slot;
      ok_r     <= slot_ok;
    end
  end

  acs_edge #(.PIVOT_FRAC_BITS(PIVOT_FRAC_BITS)) u_edge_x (
    .clk   (clk),
    .ld    (upd_acc),
    .pos   (in_pos_x),
    .size  (in_size_x),
    .pivot (in_pivot_x),
    .lo    (box_l),
    .hi    (box_r)
  );

  acs_edge #(.PIVOT_FRAC_BITS(PIVOT_FRAC_BITS)) u_edge_y (
    .clk   (clk),
    .ld    (upd_acc),
    .pos   (in_pos_y),
    .size  (in_size_y),
    .pivot (in_pivot_y),
    .lo    (box_t),
    .hi    (box_b)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      acs_pkg::S_IDLE:  if (upd_acc) state_nxt = acs_pkg::S_MUL;
      acs_pkg::S_MUL:   state_nxt = acs_pkg::S_WRITE;
      acs_pkg::S_WRITE: state_nxt = ok_r ? acs_pkg::S_SCAN : acs_pkg::S_DONE;
      acs_pkg::S_SCAN:  if (tok_exit) state_nxt = acs_pkg::S_DONE;
      acs_pkg::S_DONE:  if (out_free) state_nxt = acs_pkg::S_IDLE;
      default:          state_nxt = acs_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    launch    = 1'b0;
    emit_done = 1'b0;
    case (state_r)
      acs_pkg::S_IDLE:  in_ready = 1'b1;
      acs_pkg::S_WRITE: launch = ok_r;
      acs_pkg::S_DONE:  emit_done = out_free;
      default: begin
        in_ready  = 1'b0;
        launch    = 1'b0;
        emit_done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // one write bus: removes from the input side, updates once the box is ready
  always_comb begin
    wr        = '0;
    wr.l      = box_l;
    wr.t      = box_t;
    wr.r      = box_r;
    wr.b      = box_b;
    wr.resp   = resp_r;
    wr.active = act_r;
    if (launch) begin
      wr.upd = 1'b1;
      wr.idx = self_r;
    end else begin
      wr.clr = rem_acc && slot_ok;
      wr.idx = in_slot;
    end
  end

  always_comb begin
    q0.l    = box_l;
    q0.t    = box_t;
    q0.r    = box_r;
    q0.b    = box_b;
    q0.chan = q_chan_r;
    q0.self = self_r;
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i == 0) begin : g_head
      acs_cell #(.IDX(i)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .adv      (adv),
        .tok_in_v (launch),
        .tok_in   (q0),
        .tok_v_o  (tok_v[i]),
        .tok_o    (tok[i]),
        .hit_o    (hit[i])
      );
    end else begin : g_body
      acs_cell #(.IDX(i)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .adv      (adv),
        .tok_in_v (tok_v[i-1]),
        .tok_in   (tok[i-1]),
        .tok_v_o  (tok_v[i]),
        .tok_o    (tok[i]),
        .hit_o    (hit[i])
      );
    end
  end

  // only one query is in the row, so an OR picks out its hit
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < NCELL; i++) begin
      if (hit[i]) hit_idx = hit_idx | acs_pkg::slot_t'(i);
    end
  end

  assign cur_hit  = |hit;
  assign out_free = !out_valid_r || out_ready;
  // hold the row while a hit has nowhere to go
  assign adv      = !(cur_hit && pend_v_r && !out_free);
  assign tok_exit = tok_v[NCELL-1] && adv;

  // keep one hit pending so the final beat can carry last
  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    out_slot_nxt  = out_slot_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cur_hit && adv) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_hit_nxt   = 1'b1;
        out_slot_nxt  = pend_slot_r;
        out_last_nxt  = 1'b0;
      end
      pend_v_nxt    = 1'b1;
      pend_slot_nxt = hit_idx;
    end
    if (emit_done) begin
      out_valid_nxt = 1'b1;
      out_hit_nxt   = pend_v_r;
      out_slot_nxt  = pend_v_r ? pend_slot_r : '0;
      out_last_nxt  = 1'b1;
      pend_v_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_slot_r <= pend_slot_nxt;
    out_hit_r   <= out_hit_nxt;
    out_slot_r  <= out_slot_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_hit_slot = out_slot_r;
  assign out_last     = out_last_r;

  a_one_query: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tok_v))
    else $error("more than one query in the cell row");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
      in_ready |-> (tok_v == '0) && !pend_v_r)
    else $error("input taken while a scan is still in flight");

  a_exit_scan: assert property (@(posedge clk) disable iff (!rst_n)
      tok_exit |-> (state_r == acs_pkg::S_SCAN))
    else $error("query left the row outside a scan");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
      emit_done |=> out_valid_r && out_last_r && !pend_v_r)
    else $error("end of scan did not leave a final beat");

endmodule
